### src/trmt_pkg.sv
`default_nettype none

package trmt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W     = 64;
  localparam int ACT_W     = 16;
  localparam int PRI_W     = 16;
  localparam int PROBE_W   = 7;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // operation broadcast to every cell while it walks the chain
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] mask;
    logic [ACT_W-1:0] action;
    logic [PRI_W-1:0] priority_v;
  } bcast_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               found;
    logic [ACT_W-1:0]   action;
    logic [PRI_W-1:0]   priority_v;
    logic [PROBE_W-1:0] probes;
  } tok_t;

  typedef struct packed {
    logic [KEY_W-1:0] value;
    logic [KEY_W-1:0] mask;
    logic [ACT_W-1:0] action;
    logic [PRI_W-1:0] priority_v;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [PROBE_W-1:0] probes;
    logic [PRI_W-1:0]   priority_v;
    logic [ACT_W-1:0]   action;
    logic               hit;
  } res_t;

endpackage

`default_nettype wire

### src/trmt_cell.sv
`default_nettype none

module trmt_cell #(
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire trmt_pkg::bcast_t  bc_i,
  input  wire logic [CNT_W-1:0]  count_i,
  input  wire trmt_pkg::tok_t    tok_i,
  output trmt_pkg::tok_t         tok_o,
  input  wire trmt_pkg::entry_t  nbr_i,
  output trmt_pkg::entry_t       ent_o
);
  import trmt_pkg::*;

  entry_t ent_r, ent_nxt;
  tok_t   tok_r, tok_nxt;
  logic   in_use, at_tail, tern_hit, exact;

  assign in_use   = CNT_W'(CELL_IDX) < count_i;
  assign at_tail  = CNT_W'(CELL_IDX) == count_i;
  assign tern_hit = (bc_i.key & ~ent_r.mask) == ent_r.value;
  assign exact    = (ent_r.value == bc_i.value) && (ent_r.mask == bc_i.mask);

  always_comb begin
    tok_nxt = tok_i;
    ent_nxt = ent_r;
    if (tok_i.vld) begin
      case (bc_i.op)
        OP_SEARCH: begin
          if (!tok_i.found && in_use && tern_hit) begin
            tok_nxt.found      = 1'b1;
            tok_nxt.action     = ent_r.action;
            tok_nxt.priority_v = ent_r.priority_v;
            tok_nxt.probes     = PROBE_W'(CELL_IDX + 1);
          end
        end
        OP_INSERT: begin
          if (in_use && exact) begin
            tok_nxt.found = 1'b1;
          end
          // earlier cells have all been checked for a duplicate by now
          if (at_tail && !tok_i.found) begin
            ent_nxt.value      = bc_i.value;
            ent_nxt.mask       = bc_i.mask;
            ent_nxt.action     = bc_i.action;
            ent_nxt.priority_v = bc_i.priority_v;
          end
        end
        OP_DELETE: begin
          // from the matching cell onward, pull the successor in
          if (tok_i.found || (in_use && exact)) begin
            tok_nxt.found = 1'b1;
            ent_nxt       = nbr_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign tok_o = tok_r;
  assign ent_o = ent_r;

endmodule

`default_nettype wire

### src/ternary_rule_match_table_top.sv
// Path: start_r, the token register of each cell, the pending register, then out_r.
// Flow: a new transaction is taken only after the last one completes: the token walks the
//   chain one cell per clock, and in_tready returns once the result leaves the
//   pending register, which holds while a stalled result fills the output register.
// Reset (rst_n low, synchronous) empties the table; rule storage is not cleared.
`default_nettype none

module ternary_rule_match_table_top #(
  parameter int TABLE_DEPTH = trmt_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // operation[1:0], search_key[65:2], rule_value[129:66], rule_mask[193:130],
  // rule_action[209:194], rule_priority[225:210], zero pad[231:226]
  input  wire logic [trmt_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // hit[0], match_action[16:1], match_priority[32:17], probe_count[39:33],
  // status[41:40], zero pad[47:42]
  output logic [trmt_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import trmt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  bcast_t           bc_r;
  logic             start_r;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  res_t             pend_r, pend_nxt;
  logic             out_vld_r, out_vld_nxt;
  res_t             out_r, out_nxt;
  res_t             res;
  logic             in_acc;
  tok_t             tok_last;

  tok_t   tok_w [TABLE_DEPTH+1];
  entry_t ent_w [TABLE_DEPTH];

  // inject a fresh token at the head of the chain
  always_comb begin
    tok_w[0]     = '0;
    tok_w[0].vld = start_r;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    entry_t nbr;
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign nbr = ent_w[g];
    end else begin : g_mid
      assign nbr = ent_w[g+1];
    end
    trmt_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bc_i    (bc_r),
      .count_i (count_r),
      .tok_i   (tok_w[g]),
      .tok_o   (tok_w[g+1]),
      .nbr_i   (nbr),
      .ent_o   (ent_w[g])
    );
  end

  assign tok_last  = tok_w[TABLE_DEPTH];
  assign in_tready = !busy_r && !pend_vld_r;
  assign in_acc    = in_tvalid && in_tready;

  // resolve the transaction once the token leaves the last cell
  always_comb begin
    res       = '0;
    count_nxt = count_r;
    case (bc_r.op)
      OP_SEARCH: begin
        res.hit = tok_last.found;
        if (tok_last.found) begin
          res.action     = tok_last.action;
          res.priority_v = tok_last.priority_v;
          res.probes     = tok_last.probes;
        end else begin
          res.probes = PROBE_W'(count_r);
        end
      end
      OP_INSERT: begin
        if (tok_last.found) begin
          res.status = ST_DUPLICATE;
        end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (tok_last.found) begin
          res.status = ST_OK;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy_nxt     = busy_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    // drain the output register, then advance the pending result into it
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (pend_vld_r && (!out_vld_r || out_tready)) begin
      out_vld_nxt  = 1'b1;
      out_nxt      = pend_r;
      pend_vld_nxt = 1'b0;
    end
    if (tok_last.vld) begin
      busy_nxt     = 1'b0;
      pend_vld_nxt = 1'b1;
      pend_nxt     = res;
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= 1'b0;
      busy_r     <= 1'b0;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      start_r    <= in_acc;
      busy_r     <= busy_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (tok_last.vld) begin
        count_r <= count_nxt;
      end
    end
  end

  // hold the operation for the whole walk; clear value bits under the mask
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (in_acc) begin
      bc_r.op         <= op_t'(in_tdata[1:0]);
      bc_r.key        <= in_tdata[65:2];
      bc_r.value      <= in_tdata[129:66] & ~in_tdata[193:130];
      bc_r.mask       <= in_tdata[193:130];
      bc_r.action     <= in_tdata[209:194];
      bc_r.priority_v <= in_tdata[225:210];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("rule count beyond table depth");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.vld |-> busy_r)
    else $error("token left the chain with no transaction in flight");

  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    tok_last.vld |-> !pend_vld_r)
    else $error("result overwrote a pending result");

  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> $past(tok_last.vld))
    else $error("rule count changed outside transaction completion");
`endif

endmodule

`default_nettype wire

### dv/tb_ternary_rule_match_table_top.sv
`timescale 1ns / 100ps

module tb_ternary_rule_match_table_top;
  import trmt_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;
  // the one operation code the package leaves out; the block ignores it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1150;
  // cycles without any transaction on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum {FILL_PHASE, CHURN_PHASE, DRAIN_PHASE} mix_t;

  // one row of stimulus; typed rows carry an expectation written out by hand
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] val;
    logic [KEY_W-1:0] msk;
    logic [ACT_W-1:0] act;
    logic [PRI_W-1:0] pri;
    bit               typed;
    res_t             want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // the testbench's own copy of the rule table
  logic [KEY_W-1:0] rule_val [TABLE_DEPTH];
  logic [KEY_W-1:0] rule_msk [TABLE_DEPTH];
  logic [ACT_W-1:0] rule_act [TABLE_DEPTH];
  logic [PRI_W-1:0] rule_pri [TABLE_DEPTH];
  int               rule_count = 0;

  res_t pending_results [$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  res_t want_res;
  res_t got_res;

  ternary_rule_match_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Masks of very different densities: exact rules, catch-alls, scattered
  // wildcards and contiguous low or high wildcard fields.
  function automatic logic [KEY_W-1:0] rand_mask();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return rand64();
      4, 5:    return rand64() & rand64() & rand64();
      6, 7:    return (64'd1 << $urandom_range(0, 63)) - 64'd1;
      default: return ~((64'd1 << $urandom_range(1, 63)) - 64'd1);
    endcase
  endfunction

  function automatic res_t mk_res(logic hit, logic [ACT_W-1:0] act, logic [PRI_W-1:0] pri,
                                  logic [PROBE_W-1:0] probes, status_t status);
    res_t r;
    r.hit        = hit;
    r.action     = act;
    r.priority_v = pri;
    r.probes     = probes;
    r.status     = status;
    return r;
  endfunction

  // Position of the stored rule with this exact (cleared) value and mask,
  // or rule_count when there is none.
  function automatic int find_rule(logic [KEY_W-1:0] val, logic [KEY_W-1:0] msk);
    for (int i = 0; i < rule_count; i++) begin
      if (rule_val[i] == val && rule_msk[i] == msk) return i;
    end
    return rule_count;
  endfunction

  // Apply one operation to the local table and return the result it yields.
  function automatic res_t apply_rule_op(stim_row_t s);
    res_t             r;
    logic [KEY_W-1:0] val;
    int               pos;
    r   = '0;
    val = s.val & ~s.msk;
    case (s.op)
      OP_SEARCH: begin
        r.probes = PROBE_W'(rule_count);
        for (int i = 0; i < rule_count; i++) begin
          if (rule_val[i] == (s.key & ~rule_msk[i])) begin
            r.hit        = 1'b1;
            r.action     = rule_act[i];
            r.priority_v = rule_pri[i];
            r.probes     = PROBE_W'(i + 1);
            break;
          end
        end
      end
      OP_INSERT: begin
        pos = find_rule(val, s.msk);
        // a duplicate is reported ahead of a full table
        if (pos < rule_count) begin
          r.status = ST_DUPLICATE;
        end else if (rule_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          rule_val[rule_count] = val;
          rule_msk[rule_count] = s.msk;
          rule_act[rule_count] = s.act;
          rule_pri[rule_count] = s.pri;
          rule_count++;
        end
      end
      OP_DELETE: begin
        pos = find_rule(val, s.msk);
        if (pos >= rule_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap so insertion order survives
          for (int i = pos; i + 1 < rule_count; i++) begin
            rule_val[i] = rule_val[i + 1];
            rule_msk[i] = rule_msk[i + 1];
            rule_act[i] = rule_act[i + 1];
            rule_pri[i] = rule_pri[i + 1];
          end
          rule_count--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t dir_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                        logic [KEY_W-1:0] val, logic [KEY_W-1:0] msk,
                                        logic [ACT_W-1:0] act, logic [PRI_W-1:0] pri,
                                        bit typed, res_t want);
    stim_row_t s;
    s.op    = op;
    s.key   = key;
    s.val   = val;
    s.msk   = msk;
    s.act   = act;
    s.pri   = pri;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Random item shaped by the current phase. Most searches and deletes aim at
  // stored rules, with junk placed under the wildcard bits, so that hits land
  // deep in the table and deletes really shift it.
  function automatic stim_row_t random_item(mix_t mix);
    stim_row_t s;
    int        roll;
    int        idx;
    roll    = $urandom_range(0, 99);
    s.key   = rand64();
    s.val   = rand64();
    s.msk   = rand_mask();
    s.act   = ACT_W'($urandom_range(0, 65535));
    s.pri   = PRI_W'($urandom_range(0, 65535));
    s.typed = 1'b0;
    s.want  = '0;
    idx     = (rule_count > 0) ? $urandom_range(0, rule_count - 1) : 0;
    case (mix)
      FILL_PHASE: begin
        if (roll < 80)      s.op = OP_INSERT;
        else if (roll < 95) s.op = OP_SEARCH;
        else if (roll < 98) s.op = OP_DELETE;
        else                s.op = OP_UNUSED;
      end
      CHURN_PHASE: begin
        if (roll < 45)      s.op = OP_SEARCH;
        else if (roll < 70) s.op = OP_INSERT;
        else if (roll < 95) s.op = OP_DELETE;
        else                s.op = OP_UNUSED;
      end
      default: begin
        if (roll < 75)      s.op = OP_DELETE;
        else if (roll < 95) s.op = OP_SEARCH;
        else                s.op = OP_UNUSED;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (rule_count > 0) begin
      case (s.op)
        OP_SEARCH: begin
          if (roll < 70) s.key = rule_val[idx] | (rand64() & rule_msk[idx]);
        end
        OP_INSERT: begin
          // re-insert a stored rule: duplicate
          if (roll < 15) begin
            s.msk = rule_msk[idx];
            s.val = rule_val[idx] | (rand64() & rule_msk[idx]);
          end
        end
        OP_DELETE: begin
          if (roll < 80) begin
            s.msk = rule_msk[idx];
            s.val = rule_val[idx] | (rand64() & rule_msk[idx]);
          end else if (roll < 90) begin
            // near miss: right value, one mask bit flipped
            s.msk = rule_msk[idx] ^ (64'd1 << $urandom_range(0, 63));
            s.val = rule_val[idx];
          end
        end
        default: ;
      endcase
    end
    if (s.op == OP_SEARCH && roll >= 95) s.key = (roll[0]) ? '1 : '0;
    return s;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Offer one item and hold it until the block takes it, then record the
  // result it must produce.
  task automatic send_item(input stim_row_t s);
    res_t r;
    in_tdata  <= {6'b0, s.pri, s.act, s.msk, s.val, s.key, s.op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    r = apply_rule_op(s);
    pending_results = {pending_results, (s.typed ? s.want : r)};
  endtask

  // Sender pacing: bursts of back-to-back offers separated by idle gaps.
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Hold off the sender until every outstanding result has been returned.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver stall pattern: long ready stretches, hard stalls and toggling.
  initial begin : ready_pattern
    int span;
    wait (rst_n);
    forever begin
      case ($urandom_range(0, 3))
        0: begin
          out_tready <= 1'b1;
          repeat ($urandom_range(50, 400)) @(posedge clk);
        end
        1: begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        default: begin
          span = $urandom_range(4, 60);
          repeat (span) begin
            out_tready <= ~out_tready;
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Result checker: every accepted result is compared against the oldest
  // outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with nothing outstanding, actual 0x%0h", $time, out_tdata);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        got_res  = res_t'(out_tdata[$bits(res_t)-1:0]);
        compare_field("hit", 16'(want_res.hit), 16'(got_res.hit));
        compare_field("match_action", want_res.action, got_res.action);
        compare_field("match_priority", want_res.priority_v, got_res.priority_v);
        compare_field("probe_count", 16'(want_res.probes), 16'(got_res.probes));
        compare_field("status", 16'(want_res.status), 16'(got_res.status));
        compare_field("pad", '0, 16'(out_tdata[OUT_DATA_W-1:$bits(res_t)]));
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("ternary_rule_match_table_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t dir_rows [$];
    mix_t      mix;
    int        seg_left;
    int        sent;

    // Directed part. Typed expectations only where the answer is obvious.
    // Empty table: search misses with zero probes, delete finds nothing.
    dir_rows = {dir_rows, dir_row(OP_SEARCH, '0, '0, '0, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, '1, '1, '1, '1, '1, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_DELETE, '0, '0, '0, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_NOT_FOUND))};
    // unused operation code: ignored, all fields zero
    dir_rows = {dir_rows, dir_row(OP_UNUSED, '1, '1, '1, '1, '1, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    // exact all-ones rule, then its duplicate
    dir_rows = {dir_rows, dir_row(OP_INSERT, '0, '1, '0, 16'hFFFF, 16'hFFFF, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_INSERT, '0, '1, '0, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_DUPLICATE))};
    // catch-all: value bits under the mask are cleared, so a zero value is a duplicate
    dir_rows = {dir_rows, dir_row(OP_INSERT, '0, '1, '1, 16'h1234, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_INSERT, '0, '0, '1, 16'h5555, 16'h5555, 1,
                                  mk_res(0, 0, 0, 0, ST_DUPLICATE))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, '1, '0, '0, '0, '0, 1,
                                  mk_res(1, 16'hFFFF, 16'hFFFF, 1, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, '0, '0, '0, '0, '0, 0, '0)};
    dir_rows = {dir_rows, dir_row(OP_INSERT, '0, 64'hA5, 64'hF, 16'h0001, 16'h8000, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    // shadowed by the earlier catch-all
    dir_rows = {dir_rows, dir_row(OP_SEARCH, 64'hAF, '0, '0, '0, '0, 0, '0)};
    dir_rows = {dir_rows, dir_row(OP_DELETE, '0, 64'h1, '1, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, 64'hAF, '0, '0, '0, '0, 0, '0)};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, 64'hBF, '0, '0, '0, '0, 0, '0)};
    dir_rows = {dir_rows, dir_row(OP_INSERT, '0, 64'h8000_0000_0000_0000,
                                  64'h7FFF_FFFF_FFFF_FFFF, 16'hAAAA, 16'h5555, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE,
                                  '0, '0, '0, '0, 0, '0)};
    // delete from the middle, then again once it has gone
    dir_rows = {dir_rows, dir_row(OP_DELETE, '0, 64'hA3, 64'hF, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_DELETE, '0, 64'hA3, 64'hF, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_NOT_FOUND))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, 64'h8000_0000_0000_0001,
                                  '0, '0, '0, '0, 0, '0)};
    dir_rows = {dir_rows, dir_row(OP_DELETE, '0, '1, '0, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_DELETE, '0, 64'h8000_0000_0000_0000,
                                  64'h7FFF_FFFF_FFFF_FFFF, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};
    dir_rows = {dir_rows, dir_row(OP_SEARCH, 64'h5, '0, '0, '0, '0, 1,
                                  mk_res(0, 0, 0, 0, ST_OK))};

    // hold reset once, before any traffic
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(1, 24);
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i]);
      pace_sender();
    end
    wait_for_drain();

    // Random part: fill, churn, then drain if over half full, else fill; round again.
    mix      = FILL_PHASE;
    seg_left = $urandom_range(90, 130);
    sent     = 0;
    while (sent < RANDOM_ITEMS) begin
      send_item(random_item(mix));
      sent++;
      seg_left--;
      if (seg_left <= 0) begin
        if ($urandom_range(0, 1) == 1) wait_for_drain();
        case (mix)
          FILL_PHASE: begin
            mix      = CHURN_PHASE;
            seg_left = $urandom_range(60, 150);
          end
          CHURN_PHASE: begin
            mix      = (rule_count > TABLE_DEPTH / 2) ? DRAIN_PHASE : FILL_PHASE;
            seg_left = (mix == DRAIN_PHASE) ? $urandom_range(60, 100)
                                            : $urandom_range(90, 130);
          end
          default: begin
            mix      = CHURN_PHASE;
            seg_left = $urandom_range(60, 150);
          end
        endcase
      end else begin
        pace_sender();
      end
    end

    wait_for_drain();
    // let any stray result show up before the verdict
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ternary_rule_match_table_top test passed");
    end else begin
      $display("ternary_rule_match_table_top test failed");
    end
    $finish;
  end

endmodule

### ternary_rule_match_table_top.f
src/trmt_pkg.sv
src/trmt_cell.sv
src/ternary_rule_match_table_top.sv
dv/tb_ternary_rule_match_table_top.sv
